// File: sv/rhh_pkg.sv
`default_nettype none
package rhh_pkg;

  // Lanes of the divider chain: one quotient per output field.
  localparam int unsigned NumLanes = 3;
  localparam int unsigned LaneHue  = 0;
  localparam int unsigned LaneSat  = 1;
  localparam int unsigned LaneLvl  = 2;

  // Width of one input channel on the stream.
  localparam int unsigned ChanWidth = 8;

  // Handshake flags of one pipeline stage toward its neighbors.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

// File: sv/rhh_front.sv
`default_nettype none
// Front stage: clamps the channels, finds max, min and span, and forms the
// numerator and divisor of each rounded quotient for the divider chain.
module rhh_front #(
  parameter int unsigned FRAC_BITS   = 15,
  parameter int unsigned CHANNEL_MAX = 255,
  parameter int unsigned BW          = 11,
  parameter int unsigned RW          = 28
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        valid_i,
  output logic                                       ready_o,
  input  wire  [rhh_pkg::ChanWidth-1:0]              red_i,
  input  wire  [rhh_pkg::ChanWidth-1:0]              green_i,
  input  wire  [rhh_pkg::ChanWidth-1:0]              blue_i,
  input  wire                                        use_hsl_i,
  output logic                                       valid_o,
  input  wire                                        ready_i,
  output logic [rhh_pkg::NumLanes-1:0][RW-1:0]       rem_o,
  output logic [rhh_pkg::NumLanes-1:0][BW:0]         div_o,
  output logic                                       gray_o
);

  localparam logic [BW-1:0] Cmax = BW'(CHANNEL_MAX);

  logic [BW-1:0] r, g, b, mx, mn, span, sum, gap, hden;
  logic [rhh_pkg::NumLanes-1:0][BW-1:0] num, den;
  logic [rhh_pkg::NumLanes-1:0][RW-1:0] rem_d, rem_q;
  logic [rhh_pkg::NumLanes-1:0][BW:0]   div_d, div_q;
  logic gray_d, gray_q, valid_q;

  // Clamp, extremes and the operands of the three quotients.
  always_comb begin
    r = (BW'(red_i) > Cmax) ? Cmax : BW'(red_i);
    g = (BW'(green_i) > Cmax) ? Cmax : BW'(green_i);
    b = (BW'(blue_i) > Cmax) ? Cmax : BW'(blue_i);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    sum  = mx + mn;
    gap  = (sum >= Cmax) ? (sum - Cmax) : (Cmax - sum);
    hden = Cmax - gap;
    gray_d = (r == g) && (g == b);

    // Hue sector numerator over six spans; a zero span divides 0 by 1.
    if (span == '0) begin
      num[rhh_pkg::LaneHue] = '0;
      den[rhh_pkg::LaneHue] = BW'(1);
    end else begin
      den[rhh_pkg::LaneHue] = BW'(6) * span;
      if (mx == r) begin
        if (g >= b) num[rhh_pkg::LaneHue] = g - b;
        else        num[rhh_pkg::LaneHue] = BW'(6) * span - (b - g);
      end else if (mx == g) begin
        num[rhh_pkg::LaneHue] = BW'(2) * span + b - r;
      end else begin
        num[rhh_pkg::LaneHue] = BW'(4) * span + r - g;
      end
    end

    // Saturation and level for the selected model.
    if (use_hsl_i) begin
      if (span == '0 || hden == '0) begin
        num[rhh_pkg::LaneSat] = '0;
        den[rhh_pkg::LaneSat] = BW'(1);
      end else begin
        num[rhh_pkg::LaneSat] = span;
        den[rhh_pkg::LaneSat] = hden;
      end
      num[rhh_pkg::LaneLvl] = sum;
      den[rhh_pkg::LaneLvl] = BW'(2) * Cmax;
    end else begin
      if (mx == '0) begin
        num[rhh_pkg::LaneSat] = '0;
        den[rhh_pkg::LaneSat] = BW'(1);
      end else begin
        num[rhh_pkg::LaneSat] = span;
        den[rhh_pkg::LaneSat] = mx;
      end
      num[rhh_pkg::LaneLvl] = mx;
      den[rhh_pkg::LaneLvl] = Cmax;
    end

    // Round to nearest: (2*num*ONE + den) / (2*den).
    for (int i = 0; i < rhh_pkg::NumLanes; i++) begin
      rem_d[i] = (RW'(num[i]) << (FRAC_BITS + 1)) + RW'(den[i]);
      div_d[i] = {den[i], 1'b0};
    end
  end

  assign ready_o = !valid_q || ready_i;

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rem_q  <= rem_d;
      div_q  <= div_d;
      gray_q <= gray_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign gray_o  = gray_q;

endmodule
`default_nettype wire

// File: sv/rhh_div_cell.sv
`default_nettype none
// One cell of the divider chain: settles quotient bit BIT of every lane by a
// trial subtraction of the shifted divisor, then hands the item on.
module rhh_div_cell #(
  parameter int unsigned FRAC_BITS = 15,
  parameter int unsigned BW        = 11,
  parameter int unsigned RW        = 28,
  parameter int unsigned BIT       = 15
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire  rhh_pkg::hs_t                         up_i,
  output logic                                       ready_o,
  input  wire  [rhh_pkg::NumLanes-1:0][RW-1:0]       rem_i,
  input  wire  [rhh_pkg::NumLanes-1:0][BW:0]         div_i,
  input  wire  [rhh_pkg::NumLanes-1:0][FRAC_BITS:0]  quo_i,
  input  wire                                        gray_i,
  output logic                                       valid_o,
  output logic [rhh_pkg::NumLanes-1:0][RW-1:0]       rem_o,
  output logic [rhh_pkg::NumLanes-1:0][BW:0]         div_o,
  output logic [rhh_pkg::NumLanes-1:0][FRAC_BITS:0]  quo_o,
  output logic                                       gray_o
);

  logic [rhh_pkg::NumLanes-1:0][RW-1:0]      rem_d, rem_q;
  logic [rhh_pkg::NumLanes-1:0][BW:0]        div_q;
  logic [rhh_pkg::NumLanes-1:0][FRAC_BITS:0] quo_d, quo_q;
  logic [rhh_pkg::NumLanes-1:0][RW-1:0]      trial;
  logic gray_q, valid_q;

  // Trial subtraction in each lane.
  always_comb begin
    for (int i = 0; i < rhh_pkg::NumLanes; i++) begin
      trial[i] = RW'(div_i[i]) << BIT;
      rem_d[i] = rem_i[i];
      quo_d[i] = quo_i[i];
      if (rem_i[i] >= trial[i]) begin
        rem_d[i] = rem_i[i] - trial[i];
        quo_d[i][BIT] = 1'b1;
      end
    end
  end

  // The up flags carry valid from the previous cell and ready from the next.
  assign ready_o = !valid_q || up_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_i.valid && ready_o) begin
      rem_q  <= rem_d;
      div_q  <= div_i;
      quo_q  <= quo_d;
      gray_q <= gray_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quo_o   = quo_q;
  assign gray_o  = gray_q;

endmodule
`default_nettype wire

// File: sv/rgb_to_hsv_hsl.sv
`default_nettype none
// Channel | Direction | Carries
// s_axis  | in        | tdata: red, green, blue (8 bits each, red lowest)
// m_axis  | out       | tdata: hue, saturation, level; tuser: gray flag
// cfg     | in        | use_hsl mode bit, written whenever cfg_we_i is high
//
// One pixel per clock is accepted while the output is not stalled; each passes
// through one front stage plus one divider cell per quotient bit.
// Every stage moves on when its successor is empty or moving, so a stalled
// output only holds back stages that are full; bubbles close up.
// Reset empties the pipeline and selects HSV mode.
module rgb_to_hsv_hsl #(
  parameter int unsigned FRAC_BITS   = 15,
  parameter int unsigned CHANNEL_MAX = 255
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  input  wire  [3*rhh_pkg::ChanWidth-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // Fields from bit 0: hue_frac, sat_frac, level_frac, zero fill.
  output logic [((3*FRAC_BITS+2+7)/8)*8-1:0]    m_axis_tdata,
  // Fields from bit 0: is_gray.
  output logic                                  m_axis_tuser,
  input  wire                                   cfg_we_i,
  input  wire                                   cfg_wdata_i
);

  localparam int unsigned BW0   = $clog2(6 * CHANNEL_MAX + 1);
  localparam int unsigned BW    = (BW0 < 9) ? 9 : BW0;
  localparam int unsigned RW    = BW + FRAC_BITS + 2;
  localparam int unsigned NC    = FRAC_BITS + 1;
  localparam int unsigned OutW  = ((3 * FRAC_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned FldW  = 3 * FRAC_BITS + 2;
  localparam int unsigned CW    = rhh_pkg::ChanWidth;

  logic use_hsl_q;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_hsl_q <= 1'b0;
    end else if (cfg_we_i) begin
      use_hsl_q <= cfg_wdata_i;
    end
  end

  // Chain links: index 0 is the front stage output, index k the k-th cell.
  logic [NC:0]                                          v;
  logic [NC:0]                                          rdy;
  logic [NC:0][rhh_pkg::NumLanes-1:0][RW-1:0]           rem;
  logic [NC:0][rhh_pkg::NumLanes-1:0][BW:0]             dv;
  logic [NC:0][rhh_pkg::NumLanes-1:0][FRAC_BITS:0]      quo;
  logic [NC:0]                                          gray;

  assign quo[0] = '0;

  rhh_front #(
    .FRAC_BITS  (FRAC_BITS),
    .CHANNEL_MAX(CHANNEL_MAX),
    .BW         (BW),
    .RW         (RW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .red_i    (s_axis_tdata[CW-1:0]),
    .green_i  (s_axis_tdata[2*CW-1:CW]),
    .blue_i   (s_axis_tdata[3*CW-1:2*CW]),
    .use_hsl_i(use_hsl_q),
    .valid_o  (v[0]),
    .ready_i  (rdy[0]),
    .rem_o    (rem[0]),
    .div_o    (dv[0]),
    .gray_o   (gray[0])
  );

  // Divider cells, most significant quotient bit first.
  for (genvar k = 0; k < NC; k++) begin : g_cell
    rhh_pkg::hs_t up;
    assign up.valid = v[k];
    assign up.ready = rdy[k+1];

    rhh_div_cell #(
      .FRAC_BITS(FRAC_BITS),
      .BW       (BW),
      .RW       (RW),
      .BIT      (FRAC_BITS - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .up_i   (up),
      .ready_o(rdy[k]),
      .rem_i  (rem[k]),
      .div_i  (dv[k]),
      .quo_i  (quo[k]),
      .gray_i (gray[k]),
      .valid_o(v[k+1]),
      .rem_o  (rem[k+1]),
      .div_o  (dv[k+1]),
      .quo_o  (quo[k+1]),
      .gray_o (gray[k+1])
    );
  end

  // Output packing; a hue that rounds to one turn wraps to zero.
  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS:0]   hue_q_full;

  assign hue_q_full = quo[NC][rhh_pkg::LaneHue];
  assign hue = hue_q_full[FRAC_BITS] ? '0 : hue_q_full[FRAC_BITS-1:0];

  assign rdy[NC]       = m_axis_tready;
  assign m_axis_tvalid = v[NC];
  assign m_axis_tuser  = gray[NC];
  assign m_axis_tdata  = OutW'({quo[NC][rhh_pkg::LaneLvl],
                                quo[NC][rhh_pkg::LaneSat], hue});

  // FldW documents the packed field span inside the padded tdata.
  logic unused_ok;
  assign unused_ok = (FldW <= OutW) & rem[NC][0][0] & dv[NC][0][0];

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int unsigned FracBits = 15;
  localparam int unsigned ChanMax = 255;
  localparam int unsigned OutWidth = ((3 * FracBits + 2 + 7) / 8) * 8;
  localparam int unsigned Latency = FracBits + 2;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] level;
    logic        gray;
  } hsx_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       chk;
    hsx_t       res;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  logic hsl_mode = 1'b0;
  hsx_t pending_q[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_sink = 1'b0;
  int idle_cycles = 0;

  rgb_to_hsv_hsl #(.FRAC_BITS(FracBits), .CHANNEL_MAX(ChanMax)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] div_round(logic [63:0] num, logic [63:0] den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Computes hue, saturation, level and gray flag for one pixel in the given mode.
  function automatic hsx_t convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8,
                                         logic hsl);
    logic [63:0] r, g, b, mx, mn, span, n, h, sum, gap, den, sat, lvl;
    hsx_t o;
    r = 64'(r8); g = 64'(g8); b = 64'(b8);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    h = 0;
    if (span != 0) begin
      if (mx == r) n = (g >= b) ? g - b : 6 * span - (b - g);
      else if (mx == g) n = 2 * span + b - r;
      else n = 4 * span + r - g;
      h = div_round(n << FracBits, 6 * span);
      if (h >= (64'd1 << FracBits)) h = 0;
    end
    sat = 0;
    if (hsl) begin
      sum = mx + mn;
      gap = (sum >= ChanMax) ? sum - ChanMax : ChanMax - sum;
      den = (gap <= ChanMax) ? ChanMax - gap : 0;
      lvl = div_round(sum << FracBits, 2 * ChanMax);
      if (span != 0 && den != 0) sat = div_round(span << FracBits, den);
    end else begin
      lvl = div_round(mx << FracBits, ChanMax);
      if (mx != 0) sat = div_round(span << FracBits, mx);
    end
    o.hue = h[14:0];
    o.sat = sat[15:0];
    o.level = lvl[15:0];
    o.gray = (r == g && g == b);
    return o;
  endfunction

  // Watchdog: cycles in which no transaction happens on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    hsx_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (m_axis_tdata[14:0] !== exp_r.hue) begin
          $error("hue_frac expected %0d actual %0d", exp_r.hue, m_axis_tdata[14:0]);
          errors++;
        end
        if (m_axis_tdata[30:15] !== exp_r.sat) begin
          $error("sat_frac expected %0d actual %0d", exp_r.sat, m_axis_tdata[30:15]);
          errors++;
        end
        if (m_axis_tdata[46:31] !== exp_r.level) begin
          $error("level_frac expected %0d actual %0d", exp_r.level, m_axis_tdata[46:31]);
          errors++;
        end
        if (m_axis_tuser !== exp_r.gray) begin
          $error("is_gray expected %0d actual %0d", exp_r.gray, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver ready, stalling at the current rate unless held off.
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
  end

  // Offers one pixel and waits for its transaction; records the expectation.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic chk, hsx_t res);
    hsx_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    pred = convert_pixel(r, g, b, hsl_mode);
    if (chk && pred !== res) begin
      $error("table row %0d/%0d/%0d: expected %h predicted %h", r, g, b, res, pred);
      errors++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(pred);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic set_mode(logic hsl);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hsl;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    hsl_mode = hsl;
  endtask

  task automatic random_pixels(int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      case ($urandom_range(7))
        0: g = r;
        1: b = r;
        2: begin g = r; b = r; end
        3: r = $urandom_range(1) ? 8'd255 : 8'd0;
        default: ;
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end
  endtask

  // Directed rows: extremes, gray, black, ties and hue wrap.
  pixel_row_t rows[$] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0, 16'd0, 16'd0, 1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0, 16'd0, 16'd32768, 1'b1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0, 16'd32768, 16'd32768, 1'b0}},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd170, 8'd85,  8'd85,  1'b0, '0},
    '{8'd10,  8'd200, 8'd200, 1'b0, '0},
    '{8'd200, 8'd10,  8'd200, 1'b0, '0},
    '{8'd254, 8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd255, 1'b0, '0}
  };

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].chk, rows[i].res);
    set_mode(1'b1);
    foreach (rows[i]) send_pixel(rows[i].r, rows[i].g, rows[i].b, 1'b0, '0);

    // Random phases across idling mixes and both modes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
        1: begin src_idle_pct = 51; snk_idle_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_idle_pct = 51; end
        default: begin src_idle_pct = 37; snk_idle_pct = 37; end
      endcase
      set_mode(ph[0] ^ ph[2]);
      random_pixels(150);
    end

    // Long receiver hold-off while the sender keeps offering.
    src_idle_pct = 0; snk_idle_pct = 0;
    fork
      begin
        hold_sink = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_sink = 1'b0;
      end
      random_pixels(60);
    join
    drain();
    random_pixels(40);

    drain();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
sv/rhh_pkg.sv
sv/rhh_front.sv
sv/rhh_div_cell.sv
sv/rgb_to_hsv_hsl.sv
test/testbench.sv
